/* rtl/qtd_pkg.sv */
// Shared types, constants and helpers for the quadtree image decoder.
// No dependencies; imported by qtd_cfg_regs and quadtree_image_decoder.
package qtd_pkg;

    localparam int MAX_DEPTH  = 16;
    localparam int COORD_BITS = 16;
    localparam int LVL_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int OUT_W      = 16;
    localparam logic [7:0] OPAQUE = 8'hff;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEAF   = 2'd2;
    localparam logic [1:0] REG_SPLIT  = 2'd3;

    localparam logic [1:0] LAST_CHILD = 2'd3;

    localparam logic KIND_FILL     = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [LVL_W-1:0]      t_level;

    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
    } t_region;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  leaf;
        logic [7:0]  split;
    } t_cfg;

    function automatic t_coord midpoint(t_coord a, t_coord b);
        logic [COORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COORD_BITS:1];
    endfunction

    function automatic t_region child_of(t_region p, logic [1:0] k);
        t_region c;
        t_coord  mx;
        t_coord  my;
        mx   = midpoint(p.x1, p.x2);
        my   = midpoint(p.y1, p.y2);
        c.x1 = k[0] ? mx   : p.x1;
        c.x2 = k[0] ? p.x2 : mx;
        c.y1 = k[1] ? my   : p.y1;
        c.y2 = k[1] ? p.y2 : my;
        return c;
    endfunction

endpackage

/* rtl/qtd_cfg_regs.sv */
// APB register file for the quadtree image decoder.
// Depends on qtd_pkg for the register map and the t_cfg bundle.
module qtd_cfg_regs
    import qtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= 16'd256;
            r_cfg.height <= 16'd256;
            r_cfg.leaf   <= 8'd0;
            r_cfg.split  <= 8'd1;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_cfg.width  <= pwdata[15:0];
                REG_HEIGHT: r_cfg.height <= pwdata[15:0];
                REG_LEAF:   r_cfg.leaf   <= pwdata[7:0];
                REG_SPLIT:  r_cfg.split  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {16'd0, r_cfg.width};
            REG_HEIGHT: prdata = {16'd0, r_cfg.height};
            REG_LEAF:   prdata = {24'd0, r_cfg.leaf};
            REG_SPLIT:  prdata = {24'd0, r_cfg.split};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/quadtree_image_decoder.sv */
// Quadtree image decoder top level: byte stream in, fill rectangles out.
// Depends on qtd_pkg and qtd_cfg_regs.
//
//   channel  direction  beat
//   s        in         tdata[7:0] stream_byte
//   m        out        tdata x_left,y_top,x_right,y_bottom,red,green,blue; tuser kind;
//                       tlast image_done
//   apb      in/out     root width, root height, leaf code, split code
//
// One byte per cycle sustained when not stalled; a byte is held in the input register and
// its result (if any) appears in the output register in the cycle after it is decoded.
// The decode step is a priority pop over the child-index stack plus the x and y midpoint adds.
// A byte that yields a result stalls only while the output register is full and m is
// not ready. Synchronous reset returns the decoder to the root; no clearing pass.
module quadtree_image_decoder
    import qtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] stream_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [87:0]       o_m_tdata,   // x_left, y_top, x_right, y_bottom, red, green, blue
    output logic              o_m_tuser,   // kind
    output logic              o_m_tlast,   // image_done
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [1:0] PH_MARK  = 2'd0;
    localparam logic [1:0] PH_RED   = 2'd1;
    localparam logic [1:0] PH_GREEN = 2'd2;
    localparam logic [1:0] PH_BLUE  = 2'd3;

    t_cfg w_cfg;

    qtd_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_level      r_level;
    logic [1:0]  r_phase;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    t_region     r_cur;
    logic [1:0]  r_child [MAX_DEPTH];
    t_region     r_par   [MAX_DEPTH];

    logic        r_out_valid;
    logic        r_out_kind;
    logic        r_out_done;
    t_region     r_out_reg;
    logic [7:0]  r_out_red;
    logic [7:0]  r_out_green;
    logic [7:0]  r_out_blue;

    t_region     w_root;
    t_region     w_cur;
    t_region     w_pop_parent;
    t_level      w_pop;
    logic        w_found;
    logic        w_fire;
    logic        w_emit;
    logic        w_kind;
    logic [7:0]  w_blue;
    logic        w_finish;
    logic        w_push;
    logic        w_can_push;
    logic [LVL_W:0] w_level_inc;

    logic [1:0]  n_phase;

    assign w_root.x1 = '0;
    assign w_root.y1 = '0;
    assign w_root.x2 = t_coord'(w_cfg.width);
    assign w_root.y2 = t_coord'(w_cfg.height);
    assign w_cur     = (r_level == '0) ? w_root : r_cur;

    assign w_level_inc = {1'b0, r_level} + {{LVL_W{1'b0}}, 1'b1};
    assign w_can_push  = (w_level_inc < (LVL_W + 1)'(MAX_DEPTH));

    always_comb begin
        w_pop   = '0;
        w_found = 1'b0;
        for (int i = 1; i < MAX_DEPTH; i++) begin
            if (LVL_W'(i) <= r_level && r_child[i] != LAST_CHILD) begin
                w_pop   = LVL_W'(i);
                w_found = 1'b1;
            end
        end
    end

    assign w_pop_parent = (w_pop == t_level'(1)) ? w_root : r_par[w_pop];

    always_comb begin
        w_emit   = 1'b0;
        w_kind   = KIND_FILL;
        w_blue   = 8'd0;
        w_finish = 1'b0;
        w_push   = 1'b0;
        n_phase  = PH_MARK;
        case (r_phase)
            PH_RED:   n_phase = PH_GREEN;
            PH_GREEN: n_phase = PH_BLUE;
            PH_BLUE: begin
                w_emit   = 1'b1;
                w_blue   = r_in_byte;
                w_finish = 1'b1;
            end
            PH_MARK: begin
                if (r_in_byte == w_cfg.leaf) begin
                    n_phase = PH_RED;
                end else if (r_in_byte == w_cfg.split) begin
                    if (w_can_push) begin
                        w_push = 1'b1;
                    end else begin
                        w_emit   = 1'b1;
                        w_kind   = KIND_OVERFLOW;
                        w_finish = 1'b1;
                    end
                end else begin
                    w_finish = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign w_fire     = r_in_valid && (!w_emit || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_phase <= PH_MARK;
            r_red   <= 8'd0;
            r_green <= 8'd0;
            for (int i = 0; i < MAX_DEPTH; i++) begin
                r_child[i] <= 2'd0;
            end
        end else if (w_fire) begin
            r_phase <= n_phase;
            if (r_phase == PH_RED) begin
                r_red <= r_in_byte;
            end
            if (r_phase == PH_GREEN) begin
                r_green <= r_in_byte;
            end
            if (w_push) begin
                r_level                         <= w_level_inc[LVL_W-1:0];
                r_child[w_level_inc[LVL_W-1:0]] <= 2'd0;
            end else if (w_finish) begin
                if (w_found) begin
                    r_level        <= w_pop;
                    r_child[w_pop] <= r_child[w_pop] + 2'd1;
                end else begin
                    r_level <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_push) begin
            r_cur                         <= child_of(w_cur, 2'd0);
            r_par[w_level_inc[LVL_W-1:0]] <= w_cur;
        end else if (w_fire && w_finish && w_found) begin
            r_cur <= child_of(w_pop_parent, r_child[w_pop] + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_kind  <= w_kind;
            r_out_done  <= !w_found;
            r_out_reg   <= w_cur;
            r_out_red   <= (w_kind == KIND_FILL) ? r_red : 8'd0;
            r_out_green <= (w_kind == KIND_FILL) ? r_green : 8'd0;
            r_out_blue  <= w_blue;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_done;
    assign o_m_tdata  = {r_out_blue, r_out_green, r_out_red,
                         OUT_W'(r_out_reg.y2), OUT_W'(r_out_reg.x2),
                         OUT_W'(r_out_reg.y1), OUT_W'(r_out_reg.x1)};

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_level} < (LVL_W + 1)'(MAX_DEPTH)))
        else $error("stack level out of range");

    a_done_to_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_finish && !w_found) |=> (r_level == '0))
        else $error("root completion did not return to level zero");

    a_overflow_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_OVERFLOW) |->
            (r_out_red == 8'd0 && r_out_green == 8'd0 && r_out_blue == 8'd0))
        else $error("overflow result carries a color");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte lost");

    a_no_push_in_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_MARK) |-> !w_push)
        else $error("split taken while collecting color bytes");

endmodule
